FILE: design/rie_pkg.sv
// Shared types and constants for the RISC instruction execute core.
package rie_pkg;

	// Default depth of the data memory in 32-bit words.
	localparam int RIE_MEM_DEPTH = 4096;

	// Register that jal writes its return address into.
	localparam logic [3:0] LINK_REG = 4'd15;

	// Instruction opcodes; codes 8 through 10 are reserved and only step the PC.
	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_AND    = 4'd2,
		OP_OR     = 4'd3,
		OP_SLL    = 4'd4,
		OP_SRA    = 4'd5,
		OP_MAC    = 4'd6,
		OP_BRANCH = 4'd7,
		OP_JAL    = 4'd11,
		OP_LW     = 4'd12,
		OP_SW     = 4'd13,
		OP_JR     = 4'd14,
		OP_HALT   = 4'd15
	} op_t;

	// Branch conditions, all signed; other codes never take the branch.
	typedef enum logic [3:0] {
		COND_EQ = 4'd0,
		COND_NE = 4'd1,
		COND_GT = 4'd2,
		COND_LT = 4'd3,
		COND_GE = 4'd4,
		COND_LE = 4'd5
	} cond_t;

	// Sequencer states of the execute engine.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EX,
		ST_MAC,
		ST_ADDR1,
		ST_ADDR2,
		ST_MEM,
		ST_LOAD
	} state_t;

endpackage

FILE: design/risc_instruction_execute_core.sv
// Execute core: register file, program counter, data memory and their sequencer.

// Executes one decoded instruction per input transfer against sixteen 32-bit registers, a
// 12-bit program counter and a MEM_DEPTH-word data memory, and returns one result per
// instruction. The register file is a two-read-port memory with registered reads; a write
// in the same cycle is forwarded into the read data. ALU operations, shifts, branches, jal,
// jr, halt and reserved opcodes complete in the execute state, with the register file read
// of the next instruction overlapping the write-back of the current one. mac registers the
// product while read port A fetches the addend, then adds both and the immediate. For sw and
// lw the address is reduced modulo MEM_DEPTH by a reciprocal multiply, a back multiply
// and a final compare-subtract before the data memory port is used, and a load adds a
// registered memory read. A full output register stalls the engine until the result
// transfer completes. After reset the data memory is cleared one word per cycle, from
// the first address to the last, and no instruction is accepted until the pass ends.
module risc_instruction_execute_core
	import rie_pkg::*;
#(
	parameter int MEM_DEPTH = RIE_MEM_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         opcode,
	input  logic [3:0]         dest_reg,
	input  logic [3:0]         src_reg,
	input  logic [3:0]         second_reg,
	input  logic [3:0]         third_reg,
	input  logic [11:0]        immediate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        next_pc,
	output logic               wrote_register,
	output logic [3:0]         written_index,
	output logic signed [31:0] written_value,
	output logic               stored_word,
	output logic               halted
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MEM_DEPTH);
	localparam logic [31:0] DEPTH_W = 32'(MEM_DEPTH);
	localparam logic [AW:0] DEPTH_R = (AW + 1)'(MEM_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

	// Sequencer and architectural state.
	state_t      state_q, state_d;
	logic [11:0] pc_q;

	// Instruction held for the engine.
	op_t         op_q;
	logic [3:0]  rd_q;
	logic [3:0]  rm_q;
	logic [31:0] imm_q;

	// Register file with valid bits and registered read ports.
	logic [31:0] rf [16];
	logic [15:0] rf_vld_q;
	logic [31:0] rd_a_q, rd_b_q;

	// Intermediate results of mac and address reduction.
	logic [31:0] prod_q;
	logic [31:0] sum_q;
	logic [31:0] qest_q;
	logic [AW:0] rest_q;

	// Data memory and clearing pass.
	logic [31:0]   dmem [MEM_DEPTH];
	logic [31:0]   mem_rd_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	// Output register.
	logic        out_valid_q;
	logic [11:0] npc_q;
	logic        wrote_q;
	logic [3:0]  widx_q;
	logic [31:0] wval_q;
	logic        stored_q;
	logic        halted_q;

	// Combinational control.
	logic        fin, commit, accept, out_free;
	logic        wr_req, wr_en;
	logic [3:0]  wr_idx;
	logic [31:0] wr_val;
	logic [11:0] npc, seq;
	logic        st_req, halt_req;
	logic        mac_go, lw_issue, sw_en;
	logic        rd_a_en;
	logic [3:0]  rd_a_addr, rd_b_addr;
	logic [31:0] imm_ext;
	logic [31:0] sh_amt;
	logic        take;
	logic [64:0] recip_prod;
	logic [31:0] back_prod;
	logic [31:0] rest_full;
	logic [AW-1:0] mem_addr;

	assign seq = pc_q + 12'd1;
	assign sh_amt = rd_b_q + imm_q;
	assign out_free = !out_valid_q || out_ready;

	// Immediate extension of the incoming instruction.
	always_comb begin
		if (opcode inside {OP_SLL, OP_SRA, OP_BRANCH, OP_JAL}) begin
			imm_ext = {20'b0, immediate};
		end else begin
			imm_ext = {{20{immediate[11]}}, immediate};
		end
	end

	// Branch condition on the two register operands.
	always_comb begin
		case (cond_t'(rm_q))
			COND_EQ: take = (rd_a_q == rd_b_q);
			COND_NE: take = (rd_a_q != rd_b_q);
			COND_GT: take = ($signed(rd_b_q) < $signed(rd_a_q));
			COND_LT: take = ($signed(rd_a_q) < $signed(rd_b_q));
			COND_GE: take = !($signed(rd_a_q) < $signed(rd_b_q));
			COND_LE: take = !($signed(rd_b_q) < $signed(rd_a_q));
			default: take = 1'b0;
		endcase
	end

	// Address reduction modulo the memory depth.
	always_comb begin
		recip_prod = 65'(sum_q) * 65'(RECIP);
		back_prod = qest_q * DEPTH_W;
		rest_full = sum_q - back_prod;
		if (rest_q >= DEPTH_R) begin
			mem_addr = AW'(rest_q - DEPTH_R);
		end else begin
			mem_addr = rest_q[AW-1:0];
		end
	end

	// Next state, results and handshake.
	always_comb begin
		state_d = state_q;
		fin = 1'b0;
		wr_req = 1'b0;
		wr_idx = rd_q;
		wr_val = '0;
		npc = seq;
		st_req = 1'b0;
		halt_req = 1'b0;
		mac_go = 1'b0;
		lw_issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_EX: begin
				case (op_q)
					OP_ADD: begin
						fin = 1'b1;
						wr_req = 1'b1;
						wr_val = rd_a_q + rd_b_q + imm_q;
					end
					OP_SUB: begin
						fin = 1'b1;
						wr_req = 1'b1;
						wr_val = rd_a_q - rd_b_q - imm_q;
					end
					OP_AND: begin
						fin = 1'b1;
						wr_req = 1'b1;
						wr_val = rd_a_q & rd_b_q & imm_q;
					end
					OP_OR: begin
						fin = 1'b1;
						wr_req = 1'b1;
						wr_val = rd_a_q | rd_b_q | imm_q;
					end
					OP_SLL: begin
						fin = 1'b1;
						wr_req = 1'b1;
						wr_val = (|sh_amt[31:5]) ? '0 : (rd_a_q << sh_amt[4:0]);
					end
					OP_SRA: begin
						fin = 1'b1;
						wr_req = 1'b1;
						if (|sh_amt[31:5]) begin
							wr_val = {32{rd_a_q[31]}};
						end else begin
							wr_val = $unsigned($signed(rd_a_q) >>> sh_amt[4:0]);
						end
					end
					OP_MAC: begin
						mac_go = 1'b1;
						state_d = ST_MAC;
					end
					OP_BRANCH: begin
						fin = 1'b1;
						if (take) begin
							npc = imm_q[11:0];
						end
					end
					OP_JAL: begin
						fin = 1'b1;
						wr_req = 1'b1;
						wr_idx = LINK_REG;
						wr_val = {20'b0, seq};
						npc = imm_q[11:0];
					end
					OP_LW, OP_SW: begin
						state_d = ST_ADDR1;
					end
					OP_JR: begin
						fin = 1'b1;
						npc = rd_b_q[11:0];
					end
					OP_HALT: begin
						fin = 1'b1;
						halt_req = 1'b1;
						npc = pc_q;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_MAC: begin
				fin = 1'b1;
				wr_req = 1'b1;
				wr_val = prod_q + rd_a_q + imm_q;
			end
			ST_ADDR1: begin
				state_d = ST_ADDR2;
			end
			ST_ADDR2: begin
				state_d = ST_MEM;
			end
			ST_MEM: begin
				if (op_q == OP_SW) begin
					fin = 1'b1;
					st_req = 1'b1;
				end else begin
					lw_issue = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				fin = 1'b1;
				wr_req = 1'b1;
				wr_val = mem_rd_q;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		commit = fin && out_free;
		in_ready = !clr_busy_q && ((state_q == ST_IDLE) || commit);
		accept = in_valid && in_ready;
		if (accept) begin
			state_d = ST_EX;
		end else if (commit) begin
			state_d = ST_IDLE;
		end

		wr_en = commit && wr_req;
		sw_en = commit && st_req;

		// Port A reads the first source on a transfer and the mac addend afterwards.
		rd_a_en = accept || mac_go;
		rd_a_addr = accept ? src_reg : rm_q;
		rd_b_addr = (opcode == OP_SW || opcode == OP_JR) ? dest_reg : second_reg;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			rf_vld_q <= '0;
			out_valid_q <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				pc_q <= npc;
			end
			if (wr_en) begin
				rf_vld_q[wr_idx] <= 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// Register file write and registered reads with write forwarding.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf[wr_idx] <= wr_val;
		end
		if (rd_a_en) begin
			if (wr_en && wr_idx == rd_a_addr) begin
				rd_a_q <= wr_val;
			end else begin
				rd_a_q <= rf_vld_q[rd_a_addr] ? rf[rd_a_addr] : '0;
			end
		end
		if (accept) begin
			if (wr_en && wr_idx == rd_b_addr) begin
				rd_b_q <= wr_val;
			end else begin
				rd_b_q <= rf_vld_q[rd_b_addr] ? rf[rd_b_addr] : '0;
			end
		end
	end

	// Data memory: clearing pass, store write and registered load read.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			dmem[clr_idx_q] <= '0;
		end else if (sw_en) begin
			dmem[mem_addr] <= rd_b_q;
		end
		if (lw_issue) begin
			mem_rd_q <= dmem[mem_addr];
		end
	end

	// Instruction fields and intermediate results.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(opcode);
			rd_q <= dest_reg;
			rm_q <= third_reg;
			imm_q <= imm_ext;
		end
		if (mac_go) begin
			prod_q <= rd_a_q * rd_b_q;
		end
		if (state_q == ST_EX) begin
			sum_q <= rd_a_q + imm_q;
		end
		if (state_q == ST_ADDR1) begin
			qest_q <= recip_prod[63:32];
		end
		if (state_q == ST_ADDR2) begin
			rest_q <= rest_full[AW:0];
		end
	end

	// Result payload, loaded when an instruction completes.
	always_ff @(posedge clk) begin
		if (commit) begin
			npc_q <= npc;
			wrote_q <= wr_req;
			widx_q <= wr_req ? wr_idx : '0;
			wval_q <= wr_req ? wr_val : '0;
			stored_q <= st_req;
			halted_q <= halt_req;
		end
	end

	assign out_valid = out_valid_q;
	assign next_pc = npc_q;
	assign wrote_register = wrote_q;
	assign written_index = widx_q;
	assign written_value = $signed(wval_q);
	assign stored_word = stored_q;
	assign halted = halted_q;

endmodule
